// ----- rtl/smm_pkg.sv -----
package smm_pkg;

  localparam int MAX_DIM    = 4;
  localparam int FRAC_BITS  = 16;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W      = $clog2(MAX_DIM + 1);
  localparam int RESULT_CAP = 16;
  localparam int TOT_W      = $clog2(RESULT_CAP + 1);
  localparam int VAL_W      = 32;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int ACC_W      = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int OP_W       = 2;
  localparam int IDX_W      = 4;
  localparam int ROWCOL_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;
  localparam int DIM_RESET  = 4;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_RUN    = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_RUN,
    CMD_DIM_ERR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [ADDR_W-1:0]  addr;
    logic [VAL_W-1:0]   value;
    logic [CNT_W-1:0]   n;
    logic [CNT_W-1:0]   p;
    logic [TOT_W-1:0]   total;
  } cmd_t;

endpackage

// ----- rtl/smm_if.sv -----
interface smm_in_if import smm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [IDX_W-1:0]        elem_index;
  logic signed [VAL_W-1:0] elem_value;

  modport source (output valid, output op, output elem_index, output elem_value,
                  input ready);
  modport sink   (input valid, input op, input elem_index, input elem_value,
                  output ready);
endinterface

interface smm_out_if import smm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] product_value;
  logic [ROWCOL_W-1:0]     out_row;
  logic [ROWCOL_W-1:0]     out_col;
  logic                    dim_error;
  logic                    last;

  modport source (output valid, output product_value, output out_row, output out_col,
                  output dim_error, output last, input ready);
  modport sink   (input valid, input product_value, input out_row, input out_col,
                  input dim_error, input last, output ready);
endinterface

interface smm_cfg_if import smm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/small_matrix_multiply.sv -----
// Small matrix multiplier, Q16.16 signed fixed point, matrices up to 4 by 4.
//
// Channels: in_i carries op, elem_index and elem_value; a load A or load B
// transaction writes one element of A or B by row-major index, a run
// transaction computes C = A * B. cfg_i writes a_rows, a_cols, b_rows and
// b_cols (index 0..3) and is always ready. out_o returns one transaction per
// element of C in row-major order with out_row, out_col and last, or a single
// dim_error transaction when effective a_cols and b_rows differ. Each element is the
// exact sum of products, shifted right by 16 and clamped to 32 bits.
//
// With the back end idle a load goes through the queue into its
// store. A run starts each element once the previous one has left the
// output register: one shared multiply-accumulate unit walks the inner
// dimension (n = a_cols) one product per cycle through read, multiply and
// accumulate. Throughput: loads one per cycle while the back end is idle;
// a run holds the back end until its last element is in the output register
// while the two-entry queue keeps taking transactions. Reset returns the
// dimensions to 4 and empties queue and sequencer; the element stores keep
// their contents. A stalled receiver holds the output register and the
// sequencer; in_i stalls once the queue is full.
module small_matrix_multiply import smm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  smm_in_if.sink    in_i,
  smm_cfg_if.sink   cfg_i,
  smm_out_if.source out_o
);

  logic push, full, cmd_valid, cmd_pop;
  cmd_t cmd_in, cmd_head;

  // classify incoming transactions and snapshot the dimensions
  smm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  // decouple acceptance from execution
  smm_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_head),
    .pop_i   (cmd_pop)
  );

  // stores, multiply-accumulate sequencer and output register
  smm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .out_o       (out_o)
  );

endmodule

// ----- rtl/smm_front.sv -----
module smm_front import smm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  smm_in_if.sink    in_i,
  smm_cfg_if.sink   cfg_i,
  input  logic      full_i,
  output logic      push_o,
  output cmd_t      cmd_o
);

  logic [CFG_DATA_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [CNT_W-1:0]      m, n, br, p;
  logic [2*CNT_W-1:0]    mp;
  logic                  accept;

  function automatic logic [CNT_W-1:0] eff_dim(logic [CFG_DATA_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= CFG_DATA_W'(DIM_RESET);
      a_cols_q <= CFG_DATA_W'(DIM_RESET);
      b_rows_q <= CFG_DATA_W'(DIM_RESET);
      b_cols_q <= CFG_DATA_W'(DIM_RESET);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_A_ROWS: a_rows_q <= cfg_i.data;
        REG_A_COLS: a_cols_q <= cfg_i.data;
        REG_B_ROWS: b_rows_q <= cfg_i.data;
        REG_B_COLS: b_cols_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign m  = eff_dim(a_rows_q);
  assign n  = eff_dim(a_cols_q);
  assign br = eff_dim(b_rows_q);
  assign p  = eff_dim(b_cols_q);
  assign mp = m * p;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  always_comb begin
    cmd_o.addr  = ADDR_W'(in_i.elem_index);
    cmd_o.value = in_i.elem_value;
    cmd_o.n     = n;
    cmd_o.p     = p;
    cmd_o.total = (int'(mp) > RESULT_CAP) ? TOT_W'(RESULT_CAP) : TOT_W'(mp);
    cmd_o.kind  = CMD_RUN;
    push_o      = 1'b0;
    unique case (in_i.op)
      OP_LOAD_A: begin
        cmd_o.kind = CMD_LOAD_A;
        push_o     = accept && (int'(in_i.elem_index) < DEPTH);
      end
      OP_LOAD_B: begin
        cmd_o.kind = CMD_LOAD_B;
        push_o     = accept && (int'(in_i.elem_index) < DEPTH);
      end
      OP_RUN: begin
        cmd_o.kind = (n != br) ? CMD_DIM_ERR : CMD_RUN;
        push_o     = accept;
      end
      default: begin
        // unused op code: take the transaction and drop it
        push_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/smm_cmd_fifo.sv -----
module smm_cmd_fifo import smm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t              store_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] r;
    if (int'(ptr) == FIFO_DEPTH - 1) begin
      r = '0;
    end else begin
      r = ptr + PTR_W'(1);
    end
    return r;
  endfunction

  assign full_o  = (int'(count_q) == FIFO_DEPTH);
  assign valid_o = (count_q != '0);
  assign cmd_o   = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + FCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - FCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/smm_back.sv -----
module smm_back import smm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  smm_out_if.source out_o
);

  logic [VAL_W-1:0]         mem_a [DEPTH];
  logic [VAL_W-1:0]         mem_b [DEPTH];

  logic                     busy_q, iss_q, pend_q;
  logic [DIM_W-1:0]         i_q, j_q, k_q;
  logic [ADDR_W-1:0]        a_base_q, b_ptr_q;
  logic [CNT_W-1:0]         n_q, p_q;
  logic [TOT_W-1:0]         tot_q, cnt_q;

  logic                     s1_v_q, s1_first_q, s1_lastk_q;
  logic signed [VAL_W-1:0]  rd_a_q, rd_b_q;
  logic                     s2_v_q, s2_first_q, s2_lastk_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     done_q;

  logic                     out_valid_q;
  logic [VAL_W-1:0]         out_value_q;
  logic [ROWCOL_W-1:0]      out_row_q, out_col_q;
  logic                     out_err_q, out_last_q;

  logic                     run_pop, err_pop, load_a, load_b;
  logic                     start_elem, lastk, last_res, last_j;
  logic [ADDR_W-1:0]        a_addr;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-VAL_W:0]     upper;
  logic [VAL_W-1:0]         sat_value;

  // command dispatch: loads and runs wait for the run in flight to finish
  always_comb begin
    cmd_pop_o = 1'b0;
    if (cmd_valid_i && !busy_q) begin
      cmd_pop_o = (cmd_i.kind != CMD_DIM_ERR) || !out_valid_q;
    end
  end

  assign load_a  = cmd_pop_o && (cmd_i.kind == CMD_LOAD_A);
  assign load_b  = cmd_pop_o && (cmd_i.kind == CMD_LOAD_B);
  assign run_pop = cmd_pop_o && (cmd_i.kind == CMD_RUN);
  assign err_pop = cmd_pop_o && (cmd_i.kind == CMD_DIM_ERR);

  assign start_elem = busy_q && !pend_q && !out_valid_q;
  assign lastk      = (CNT_W'(k_q) + CNT_W'(1)) == n_q;
  assign last_j     = (CNT_W'(j_q) + CNT_W'(1)) == p_q;
  assign last_res   = (cnt_q + TOT_W'(1)) == tot_q;
  assign a_addr     = a_base_q + ADDR_W'(k_q);

  // truncate toward minus infinity, then clamp to the 32-bit range
  assign shifted   = acc_q >>> FRAC_BITS;
  assign upper     = shifted[ACC_W-1:VAL_W-1];
  assign sat_value = ((&upper) || !(|upper)) ? shifted[VAL_W-1:0] :
                     (shifted[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} :
                                         {1'b0, {(VAL_W-1){1'b1}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      iss_q       <= 1'b0;
      pend_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      a_base_q    <= '0;
      b_ptr_q     <= '0;
      n_q         <= '0;
      p_q         <= '0;
      tot_q       <= '0;
      cnt_q       <= '0;
      s1_v_q      <= 1'b0;
      s1_first_q  <= 1'b0;
      s1_lastk_q  <= 1'b0;
      s2_v_q      <= 1'b0;
      s2_first_q  <= 1'b0;
      s2_lastk_q  <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (run_pop) begin
        busy_q   <= 1'b1;
        n_q      <= cmd_i.n;
        p_q      <= cmd_i.p;
        tot_q    <= cmd_i.total;
        i_q      <= '0;
        j_q      <= '0;
        a_base_q <= '0;
        cnt_q    <= '0;
        pend_q   <= 1'b0;
        iss_q    <= 1'b0;
      end

      if (start_elem) begin
        pend_q  <= 1'b1;
        iss_q   <= 1'b1;
        k_q     <= '0;
        b_ptr_q <= ADDR_W'(j_q);
      end

      if (iss_q) begin
        if (lastk) begin
          iss_q <= 1'b0;
        end else begin
          k_q     <= k_q + DIM_W'(1);
          b_ptr_q <= b_ptr_q + ADDR_W'(p_q);
        end
      end

      s1_v_q     <= iss_q;
      s1_first_q <= (k_q == '0);
      s1_lastk_q <= lastk;
      s2_v_q     <= s1_v_q;
      s2_first_q <= s1_first_q;
      s2_lastk_q <= s1_lastk_q;
      done_q     <= s2_v_q && s2_lastk_q;

      // element finished: advance to the next row-major position, or end the run after the last
      if (done_q) begin
        pend_q <= 1'b0;
        cnt_q  <= cnt_q + TOT_W'(1);
        if (last_res) begin
          busy_q <= 1'b0;
        end else if (last_j) begin
          j_q      <= '0;
          i_q      <= i_q + DIM_W'(1);
          a_base_q <= a_base_q + ADDR_W'(n_q);
        end else begin
          j_q <= j_q + DIM_W'(1);
        end
      end

      if (done_q || err_pop) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_a) begin
      mem_a[cmd_i.addr] <= cmd_i.value;
    end
    if (load_b) begin
      mem_b[cmd_i.addr] <= cmd_i.value;
    end
    rd_a_q <= mem_a[a_addr];
    rd_b_q <= mem_b[b_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= rd_a_q * rd_b_q;
    if (s2_v_q) begin
      if (s2_first_q) begin
        acc_q <= ACC_W'(prod_q);
      end else begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
    if (done_q) begin
      out_value_q <= sat_value;
      out_row_q   <= ROWCOL_W'(i_q);
      out_col_q   <= ROWCOL_W'(j_q);
      out_err_q   <= 1'b0;
      out_last_q  <= last_res;
    end else if (err_pop) begin
      out_value_q <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_err_q   <= 1'b1;
      out_last_q  <= 1'b1;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.product_value = out_value_q;
  assign out_o.out_row       = out_row_q;
  assign out_o.out_col       = out_col_q;
  assign out_o.dim_error     = out_err_q;
  assign out_o.last          = out_last_q;

  a_done_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !out_valid_q)
    else $error("element result arrived while output slot occupied");

  a_issue_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (iss_q || s1_v_q || s2_v_q) |-> busy_q)
    else $error("multiply pipeline active outside a run");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q < tot_q))
    else $error("run emitted more results than its total");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> !busy_q)
    else $error("command taken while a run is in flight");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && last_res) |=> !busy_q && out_o.last)
    else $error("final element did not close the run");

endmodule
